>>> sv/sbod_pkg.sv
// shared types and constants for the steady and blink output driver
// no dependencies, compiled first
`default_nettype none

package sbod_pkg;

    localparam int unsigned PIN_W = 16;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_STEADY = 3'd1;
    localparam logic [2:0] CMD_BLINK  = 3'd2;
    localparam logic [2:0] CMD_LOAD   = 3'd3;
    localparam logic [2:0] CMD_PERIOD = 3'd4;
    localparam logic [2:0] CMD_SYNC   = 3'd5;

    localparam logic [15:0] DEFAULT_PERIOD = 16'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  channel;
        logic        on_off;
        logic [15:0] steady_mask_in;
        logic [15:0] blink_mask_in;
        logic [15:0] period_value;
    } sbod_in_t;

    typedef struct packed {
        logic [15:0] pins;
        logic [15:0] steady_now;
        logic [15:0] blink_now;
    } sbod_out_t;

    // sequencer to datapath controls
    typedef struct packed {
        logic walk_tick;
        logic walk_sync;
        logic done;
    } sbod_ctrl_t;

endpackage

`default_nettype wire

>>> sv/sbod_step_unit.sv
// shared counter step: increment, compare against the period, wrap and toggle
// uses no package items
`default_nettype none

module sbod_step_unit (
    input  wire logic [15:0] count,
    input  wire logic [15:0] period,
    output logic      [15:0] count_new,
    output logic             toggle
);

    logic [15:0] count_inc;

    always_comb
    begin
        count_inc = count + 16'd1;
        toggle    = count_inc > period;
        count_new = toggle ? 16'd0 : count_inc;
    end

endmodule

`default_nettype wire

>>> sv/sbod_ctrl.sv
// sequencer: takes a transaction, walks the channels for tick and sync, strobes done
// depends on sbod_pkg
`default_nettype none

module sbod_ctrl #(
    parameter int unsigned CHANNELS = 16,
    parameter int unsigned IDX_W    = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [2:0]       command,
    output logic                  busy,
    output logic [IDX_W-1:0]      idx,
    output sbod_pkg::sbod_ctrl_t  ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             sync_reg, sync_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sync_next  = sync_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next  = '0;
                    sync_next = (command == sbod_pkg::CMD_SYNC);
                    if (command == sbod_pkg::CMD_TICK || command == sbod_pkg::CMD_SYNC)
                        state_next = S_WALK;
                    else
                        state_next = S_DONE;
                end
            end
            S_WALK:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = S_DONE;
                else
                    idx_next = idx_reg + 1'b1;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            sync_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            sync_reg  <= sync_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign idx            = idx_reg;
    assign ctrl.walk_tick = (state_reg == S_WALK) && !sync_reg;
    assign ctrl.walk_sync = (state_reg == S_WALK) && sync_reg;
    assign ctrl.done      = (state_reg == S_DONE);

endmodule

`default_nettype wire

>>> sv/steady_and_blink_output_driver_top.sv
// steady and blink output driver, top level: mode masks, pin levels, period and counter banks
// depends on sbod_pkg, sbod_ctrl, sbod_step_unit
//
// channel  | signals                 | handshake
// ---------+-------------------------+----------------------------------------
// command  | cmd (sbod_in_t)         | taken at an edge with start high, busy low
// result   | result (sbod_out_t)     | valid for the one cycle that done is high
//
// tick and sync commands walk every channel: one shared step unit visits one
// channel per cycle, then a cycle with the done strobe. other commands go straight to done.
// busy stays high until the done cycle has passed; done cannot be held off.
// reset sets periods to 5, counters, masks and pins to zero, no clearing pass.
`default_nettype none

module steady_and_blink_output_driver_top #(
    parameter int unsigned CHANNELS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire sbod_pkg::sbod_in_t  cmd,
    output logic                     busy,
    output logic                     done,
    output sbod_pkg::sbod_out_t      result
);

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [15:0] CHAN_MASK = 16'((17'd1 << CHANNELS) - 17'd1);

    sbod_pkg::sbod_ctrl_t ctrl;
    logic [IDX_W-1:0]     idx;

    logic [15:0] pins_reg, pins_next;
    logic [15:0] steady_reg, steady_next;
    logic [15:0] blink_reg, blink_next;
    logic [15:0] period_reg  [CHANNELS];
    logic [15:0] counter_reg [CHANNELS];

    logic             accept;
    logic             ch_ok;
    logic [IDX_W-1:0] ch_idx;
    logic [15:0]      ch_bit;
    logic [15:0]      walk_bit;
    logic             walk_blink;
    logic [15:0]      count_new;
    logic             toggle;
    logic [15:0]      smask;
    logic [15:0]      bmask;

    sbod_ctrl #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (cmd.command),
        .busy    (busy),
        .idx     (idx),
        .ctrl    (ctrl)
    );

    sbod_step_unit u_step (
        .count     (counter_reg[idx]),
        .period    (period_reg[idx]),
        .count_new (count_new),
        .toggle    (toggle)
    );

    assign accept     = start && !busy;
    assign ch_ok      = {1'b0, cmd.channel} < 5'(CHANNELS);
    assign ch_idx     = IDX_W'(cmd.channel);
    assign ch_bit     = 16'd1 << cmd.channel;
    assign walk_bit   = 16'd1 << idx;
    assign walk_blink = |(blink_reg & walk_bit);
    assign smask      = cmd.steady_mask_in & CHAN_MASK & ~(cmd.blink_mask_in & CHAN_MASK);
    assign bmask      = cmd.blink_mask_in & CHAN_MASK;

    always_comb
    begin
        pins_next   = pins_reg;
        steady_next = steady_reg;
        blink_next  = blink_reg;
        if (accept)
        begin
            unique case (cmd.command)
                sbod_pkg::CMD_STEADY:
                begin
                    if (ch_ok)
                    begin
                        if (cmd.on_off)
                        begin
                            blink_next  = blink_reg & ~ch_bit;
                            steady_next = steady_reg | ch_bit;
                            pins_next   = pins_reg | ch_bit;
                        end
                        else
                        begin
                            steady_next = steady_reg & ~ch_bit;
                            if ((blink_reg & ch_bit) == 16'd0)
                                pins_next = pins_reg & ~ch_bit;
                        end
                    end
                end
                sbod_pkg::CMD_BLINK:
                begin
                    if (ch_ok)
                    begin
                        if (cmd.on_off)
                        begin
                            steady_next = steady_reg & ~ch_bit;
                            blink_next  = blink_reg | ch_bit;
                            pins_next   = pins_reg | ch_bit;
                        end
                        else
                        begin
                            blink_next = blink_reg & ~ch_bit;
                            if ((steady_reg & ch_bit) == 16'd0)
                                pins_next = pins_reg & ~ch_bit;
                        end
                    end
                end
                sbod_pkg::CMD_LOAD:
                begin
                    steady_next = smask;
                    blink_next  = bmask;
                    pins_next   = smask | bmask;
                end
                default:
                begin
                    // tick and sync run in the walk, unused codes change nothing
                end
            endcase
        end
        else if (ctrl.walk_tick && walk_blink && toggle)
        begin
            pins_next = pins_reg ^ walk_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pins_reg   <= '0;
            steady_reg <= '0;
            blink_reg  <= '0;
        end
        else
        begin
            pins_reg   <= pins_next;
            steady_reg <= steady_next;
            blink_reg  <= blink_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                period_reg[i]  <= sbod_pkg::DEFAULT_PERIOD;
                counter_reg[i] <= '0;
            end
        end
        else
        begin
            if (accept && cmd.command == sbod_pkg::CMD_PERIOD && ch_ok)
                period_reg[ch_idx] <= cmd.period_value;
            if (ctrl.walk_sync)
                counter_reg[idx] <= '0;
            else if (ctrl.walk_tick && walk_blink)
                counter_reg[idx] <= count_new;
        end
    end

    assign done              = ctrl.done;
    assign result.pins       = pins_reg;
    assign result.steady_now = steady_reg;
    assign result.blink_now  = blink_reg;

endmodule

`default_nettype wire
